@@ hdl/crcpr_pkg.sv @@
// Shared widths, register indexes and types for the programmable CRC block.
package crcpr_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned CrcW  = 7;
  localparam int unsigned DegW  = 3;
  localparam int unsigned GenW  = 8;
  localparam int unsigned CfgIdxW = 1;

  typedef logic [DataW-1:0]   data_t;
  typedef logic [CrcW-1:0]    crc_t;
  typedef logic [DegW-1:0]    deg_t;
  typedef logic [GenW-1:0]    gen_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t RegGenerator = 1'b0;
  localparam cfg_idx_t RegDegree    = 1'b1;

  // Reset values of the configuration registers
  localparam gen_t GenReset = 8'd137;
  localparam deg_t DegReset = 3'd7;

endpackage

@@ hdl/crc_poly_remainder_bytes.sv @@
// Top level: programmable MSB-first CRC over fixed-length byte messages.
//
//   channel  direction  handshake                  payload
//   in       sink       in_valid_i / in_stall_o    data_byte_i
//   out      source     out_valid_o / out_stall_i  check_value_o
//   cfg      sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One byte a cycle while the result register has room: a transferred byte
// is held in the input register, then the unrolled LFSR update folds it into
// the remainder; a message's last byte loads the result register instead.
// Reset clears the remainder, byte count and valid flags; registers take
// their reset values. A stalled result only holds the input side when the
// byte in the input register ends a message.
module crc_poly_remainder_bytes #(
  parameter int unsigned MESSAGE_BYTES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  crcpr_pkg::data_t    data_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output crcpr_pkg::crc_t     check_value_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  crcpr_pkg::cfg_idx_t cfg_index_i,
  input  crcpr_pkg::gen_t     cfg_data_i
);
  import crcpr_pkg::*;

  localparam int unsigned CntW = (MESSAGE_BYTES > 1) ? $clog2(MESSAGE_BYTES) : 1;
  localparam logic [CntW-1:0] LastCnt =
    (MESSAGE_BYTES > 1) ? CntW'(MESSAGE_BYTES - 1) : '0;

  gen_t generator_q;
  deg_t degree_q;
  crc_t rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic s1_valid_q, s1_valid_d;
  data_t s1_byte_q;
  crc_t step_rem;
  logic last;
  logic out_free;
  logic s1_adv;
  logic in_xfer;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      generator_q <= GenReset;
      degree_q    <= DegReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegGenerator: generator_q <= cfg_data_i;
        RegDegree:    degree_q    <= cfg_data_i[DegW-1:0];
        default: ;
      endcase
    end
  end

  assign last       = (cnt_q == LastCnt);
  assign s1_adv     = s1_valid_q && (!last || out_free);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_xfer || (s1_valid_q && !s1_adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_byte_q <= data_byte_i;
    end
  end

  crcpr_byte_step u_step (
    .rem_i       (rem_q),
    .byte_i      (s1_byte_q),
    .degree_i    (degree_q),
    .generator_i (generator_q),
    .rem_o       (step_rem)
  );

  // Advance the remainder; clear it and the count at the end of a message
  always_comb begin
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (s1_adv) begin
      if (last) begin
        rem_d = '0;
        cnt_d = '0;
      end else begin
        rem_d = step_rem;
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      cnt_q <= '0;
    end else begin
      rem_q <= rem_d;
      cnt_q <= cnt_d;
    end
  end

  crcpr_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (s1_adv && last),
    .data_i  (step_rem),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (check_value_o)
  );

endmodule

@@ hdl/crcpr_byte_step.sv @@
// Eight-bit unrolled LFSR update of the running remainder, MSB first.
module crcpr_byte_step (
  input  crcpr_pkg::crc_t  rem_i,
  input  crcpr_pkg::data_t byte_i,
  input  crcpr_pkg::deg_t  degree_i,
  input  crcpr_pkg::gen_t  generator_i,
  output crcpr_pkg::crc_t  rem_o
);
  import crcpr_pkg::*;

  crc_t mask;
  crc_t poly;
  crc_t rem;
  logic top;

  always_comb begin
    mask = crc_t'((8'd1 << degree_i) - 8'd1);
    poly = generator_i[CrcW-1:0] & mask;
    rem  = rem_i & mask;
    for (int k = 0; k < DataW; k++) begin
      if (degree_i == '0) begin
        top = 1'b0;
      end else begin
        top = rem[degree_i - deg_t'(1)] ^ byte_i[DataW-1-k];
      end
      rem = crc_t'(rem << 1) & mask;
      if (top) begin
        rem = rem ^ poly;
      end
    end
    rem_o = rem;
  end

endmodule

@@ hdl/crcpr_out_reg.sv @@
// Result register with valid and stall towards the consumer.
module crcpr_out_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  crcpr_pkg::crc_t data_i,
  output logic            free_o,
  output logic            valid_o,
  input  logic            stall_i,
  output crcpr_pkg::crc_t data_o
);
  import crcpr_pkg::*;

  logic valid_q, valid_d;
  crc_t data_q;

  // Space for a new result when empty or when the held one transfers now
  assign free_o  = !valid_q || !stall_i;
  assign valid_d = load_i || (valid_q && stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
